// ===== hdl/lpfc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfc_pkg
// Shared widths and controller/datapath handshake types of the LRU page
// fault counter.
// ----------------------------------------------------------------------------
package lpfc_pkg;

  localparam int unsigned PAGE_W  = 16;  // page number width
  localparam int unsigned STAMP_W = 32;  // last-use stamp / access clock
  localparam int unsigned COUNT_W = 32;  // fault counter
  localparam int unsigned CAP_W   = 5;   // capacity register

  // controller -> datapath
  typedef struct packed {
    logic accept;  // latch a new word, clear trackers
    logic rd;      // read frame at scan index, advance index
    logic write;   // commit replacement decision, emit result
  } lpfc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_idx;  // scan index sits on the last frame
  } lpfc_sts_t;

endpackage

// ===== hdl/lpfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpfc_ctrl
// Sequencer: accept, scan all frames one per cycle, drain the read pipe,
// commit the replacement.
// ----------------------------------------------------------------------------
module lpfc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  lpfc_pkg::lpfc_sts_t sts_i,
  output lpfc_pkg::lpfc_cmd_t cmd_o,
  output logic              busy
);
  import lpfc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE
  } state_e;

  state_e state_q;
  logic   busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_SCAN;
            busy_q  <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (sts_i.last_idx) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_WRITE;
        end
        ST_WRITE: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = (state_q == ST_IDLE) && start;
    cmd_o.rd     = (state_q == ST_SCAN);
    cmd_o.write  = (state_q == ST_WRITE);
  end

  assign busy = busy_q;

endmodule

// ===== hdl/lpfc_dp.sv =====
// ----------------------------------------------------------------------------
// lpfc_dp
// Datapath: frame memory, valid bits, scan trackers (hit / free / oldest),
// access clock, fault counter, capacity register and result registers.
// ----------------------------------------------------------------------------
module lpfc_dp #(
  parameter int unsigned CAPACITY_MAX = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lpfc_pkg::lpfc_cmd_t          cmd_i,
  output lpfc_pkg::lpfc_sts_t          sts_o,
  input  logic                         cfg_we_i,
  input  logic [lpfc_pkg::CAP_W-1:0]   cfg_data_i,
  input  logic [lpfc_pkg::PAGE_W-1:0]  page_i,
  input  logic                         new_sequence_i,
  input  logic                         last_in_sequence_i,
  output logic                         result_valid_o,
  output logic                         fault_o,
  output logic [lpfc_pkg::COUNT_W-1:0] fault_count_o,
  output logic                         evicted_valid_o,
  output logic [lpfc_pkg::PAGE_W-1:0]  evicted_page_o,
  output logic                         sequence_done_o
);
  import lpfc_pkg::*;

  localparam int unsigned IW    = (CAPACITY_MAX > 1) ? $clog2(CAPACITY_MAX) : 1;
  localparam int unsigned CNTW  = $clog2(CAPACITY_MAX + 1);
  localparam int unsigned EW    = (CNTW > CAP_W) ? CNTW : CAP_W;
  localparam int unsigned MEM_W = PAGE_W + STAMP_W;
  localparam logic [IW-1:0]    LAST_IDX  = IW'(CAPACITY_MAX - 1);
  localparam logic [EW-1:0]    CAP_LIMIT = EW'(CAPACITY_MAX);
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // frame memory: {page, last-use stamp}
  logic [MEM_W-1:0] mem_q [CAPACITY_MAX];
  logic [CAPACITY_MAX-1:0] valid_q;

  // current word
  logic [PAGE_W-1:0]  page_q;
  logic               last_q;
  logic [STAMP_W-1:0] stamp_q;
  logic [STAMP_W-1:0] clock_q;
  logic [COUNT_W-1:0] faults_q;

  // capacity register; dflt means "as built"
  logic [CAP_W-1:0] cap_q;
  logic             cap_dflt_q;

  // scan pipe
  logic [IW-1:0]      idx_q;
  logic               eval_q;
  logic [IW-1:0]      rd_idx_q;
  logic               rd_valid_q;
  logic [MEM_W-1:0]   rd_word_q;
  logic [PAGE_W-1:0]  rd_page;
  logic [STAMP_W-1:0] rd_stamp;

  // trackers
  logic               hit_f_q,  hit_f_d;
  logic [IW-1:0]      hit_idx_q, hit_idx_d;
  logic               free_f_q, free_f_d;
  logic [IW-1:0]      free_idx_q, free_idx_d;
  logic               old_f_q,  old_f_d;
  logic [IW-1:0]      old_idx_q, old_idx_d;
  logic [STAMP_W-1:0] old_stamp_q, old_stamp_d;
  logic [PAGE_W-1:0]  old_page_q, old_page_d;
  logic [CNTW-1:0]    occ_q, occ_d;

  // commit decision
  logic [EW-1:0]      cap_x, cap_eff;
  logic               use_free, evict;
  logic [IW-1:0]      slot;
  logic [COUNT_W-1:0] faults_d;
  logic [STAMP_W-1:0] clock_base;

  assign rd_page  = rd_word_q[MEM_W-1 -: PAGE_W];
  assign rd_stamp = rd_word_q[STAMP_W-1:0];
  assign sts_o.last_idx = (idx_q == LAST_IDX);

  // scan evaluation, one frame per cycle
  always_comb begin
    hit_f_d     = hit_f_q;
    hit_idx_d   = hit_idx_q;
    free_f_d    = free_f_q;
    free_idx_d  = free_idx_q;
    old_f_d     = old_f_q;
    old_idx_d   = old_idx_q;
    old_stamp_d = old_stamp_q;
    old_page_d  = old_page_q;
    occ_d       = occ_q;
    if (eval_q) begin
      if (rd_valid_q) begin
        occ_d = occ_q + CNTW'(1);
        if (!hit_f_q && (rd_page == page_q)) begin
          hit_f_d   = 1'b1;
          hit_idx_d = rd_idx_q;
        end
        // strict less keeps the lowest frame among equal stamps
        if (!old_f_q || (rd_stamp < old_stamp_q)) begin
          old_f_d     = 1'b1;
          old_idx_d   = rd_idx_q;
          old_stamp_d = rd_stamp;
          old_page_d  = rd_page;
        end
      end else if (!free_f_q) begin
        free_f_d   = 1'b1;
        free_idx_d = rd_idx_q;
      end
    end
  end

  // capacity clamp: 0 acts as 1, above the build size acts as the build size
  always_comb begin
    cap_x = EW'(cap_q);
    if (cap_dflt_q) begin
      cap_eff = CAP_LIMIT;
    end else if (cap_x == '0) begin
      cap_eff = EW'(1);
    end else if (cap_x > CAP_LIMIT) begin
      cap_eff = CAP_LIMIT;
    end else begin
      cap_eff = cap_x;
    end
  end

  assign use_free = free_f_q && (EW'(occ_q) < cap_eff);
  assign evict    = !hit_f_q && !use_free;
  assign slot     = hit_f_q ? hit_idx_q : (use_free ? free_idx_q : old_idx_q);
  assign faults_d = (!hit_f_q && (faults_q != COUNT_MAX)) ? faults_q + COUNT_W'(1)
                                                          : faults_q;
  assign clock_base = new_sequence_i ? '0 : clock_q;

  // memory: one read port for the scan, one write at commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_word_q <= mem_q[idx_q];
      rd_idx_q  <= idx_q;
    end
    if (cmd_i.write) begin
      mem_q[slot] <= {page_q, stamp_q};
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      page_q  <= page_i;
      last_q  <= last_in_sequence_i;
      stamp_q <= clock_base;
    end
    if (cmd_i.write) begin
      fault_o         <= !hit_f_q;
      fault_count_o   <= faults_d;
      evicted_valid_o <= evict;
      evicted_page_o  <= evict ? old_page_q : '0;
      sequence_done_o <= last_q;
    end
    hit_idx_q   <= hit_idx_d;
    free_idx_q  <= free_idx_d;
    old_idx_q   <= old_idx_d;
    old_stamp_q <= old_stamp_d;
    old_page_q  <= old_page_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q        <= '0;
      clock_q        <= '0;
      faults_q       <= '0;
      cap_q          <= '0;
      cap_dflt_q     <= 1'b1;
      idx_q          <= '0;
      eval_q         <= 1'b0;
      rd_valid_q     <= 1'b0;
      hit_f_q        <= 1'b0;
      free_f_q       <= 1'b0;
      old_f_q        <= 1'b0;
      occ_q          <= '0;
      result_valid_o <= 1'b0;
    end else begin
      eval_q         <= cmd_i.rd;
      result_valid_o <= cmd_i.write;
      if (cfg_we_i) begin
        cap_q      <= cfg_data_i;
        cap_dflt_q <= 1'b0;
      end
      if (cmd_i.accept) begin
        if (new_sequence_i) begin
          valid_q  <= '0;
          faults_q <= '0;
        end
        clock_q  <= (clock_base != STAMP_MAX) ? clock_base + STAMP_W'(1) : clock_base;
        idx_q    <= '0;
        hit_f_q  <= 1'b0;
        free_f_q <= 1'b0;
        old_f_q  <= 1'b0;
        occ_q    <= '0;
      end else begin
        hit_f_q  <= hit_f_d;
        free_f_q <= free_f_d;
        old_f_q  <= old_f_d;
        occ_q    <= occ_d;
        if (cmd_i.rd) begin
          rd_valid_q <= valid_q[idx_q];
          idx_q      <= idx_q + IW'(1);
        end
        if (cmd_i.write) begin
          valid_q[slot] <= 1'b1;
          faults_q      <= faults_d;
        end
      end
    end
  end

endmodule

// ===== hdl/lru_page_fault_counter.sv =====
// ----------------------------------------------------------------------------
// lru_page_fault_counter
// Fully associative LRU page store with fault counting and eviction report.
// ----------------------------------------------------------------------------
// Usage:
//   Input words are offered on page_i / new_sequence_i / last_in_sequence_i
//   and taken on a rising edge with start high and busy low. new_sequence_i
//   empties all frames and zeroes the access clock and fault count before
//   the word is handled.
//   Each word yields one result word, shown for exactly one cycle while
//   result_valid_o is high: fault, running fault count (saturating), evicted
//   page if any, and sequence_done_o echoing last_in_sequence_i. The
//   receiver cannot stall; results must be captured when strobed.
//   The frame memory has one read port, so the tag/stamp scan reads one
//   frame per cycle over all CAPACITY_MAX frames, then drains the read pipe
//   and commits; the result appears the cycle after commit, when busy is
//   low again. A new word is taken only once the previous one is done.
//   Capacity is written via cfg_valid_i / cfg_ready_o / cfg_data_i (always
//   ready), by the user only while the block is idle; the block does not
//   enforce it. 0 acts as 1; values above CAPACITY_MAX act as CAPACITY_MAX.
//   Reset: frames empty, counters zero, capacity = CAPACITY_MAX. No clearing
//   pass is needed; frame valid bits live in flops.
// ----------------------------------------------------------------------------
module lru_page_fault_counter #(
  parameter int unsigned CAPACITY_MAX = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  logic [lpfc_pkg::PAGE_W-1:0]  page_i,
  input  logic                         new_sequence_i,
  input  logic                         last_in_sequence_i,
  // result channel
  output logic                         result_valid_o,
  output logic                         fault_o,
  output logic [lpfc_pkg::COUNT_W-1:0] fault_count_o,
  output logic                         evicted_valid_o,
  output logic [lpfc_pkg::PAGE_W-1:0]  evicted_page_o,
  output logic                         sequence_done_o,
  // capacity register write
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lpfc_pkg::CAP_W-1:0]   cfg_data_i
);
  import lpfc_pkg::*;

  lpfc_cmd_t cmd;
  lpfc_sts_t sts;

  // user issues register writes only while idle; not enforced, always ready
  assign cfg_ready_o = 1'b1;

  lpfc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  lpfc_dp #(
    .CAPACITY_MAX (CAPACITY_MAX)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .page_i             (page_i),
    .new_sequence_i     (new_sequence_i),
    .last_in_sequence_i (last_in_sequence_i),
    .result_valid_o     (result_valid_o),
    .fault_o            (fault_o),
    .fault_count_o      (fault_count_o),
    .evicted_valid_o    (evicted_valid_o),
    .evicted_page_o     (evicted_page_o),
    .sequence_done_o    (sequence_done_o)
  );

endmodule
